@@ src/zrff_pkg.sv @@
// Package for the zero-run first-fit allocator: field widths, op codes,
// controller states and the command and status structs between the two halves.
// Depends on nothing; every module of the block imports it.
package zrff_pkg;

    localparam int unsigned SIZE_W = 9;
    localparam int unsigned ADDR_W = 8;
    localparam int unsigned DATA_W = 8;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned RUN_W  = 10;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ALLOC,
        ST_FREE,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        RES_HOLD,
        RES_FAIL,
        RES_DONE,
        RES_FOUND
    } res_cmd_t;

    typedef struct packed {
        logic     load;
        logic     start;
        logic     issue;
        logic     check;
        logic     write;
        logic     clear;
        res_cmd_t res;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            len_zero;
        logic            addr_in_pool;
        logic            chk_vld;
        logic            chk_zero;
        logic            chk_last;
        logic            fits;
        logic            cand_big;
    } dp_sts_t;

endpackage

@@ src/zrff_dp.sv @@
// Datapath of the allocator: pool memory with per-byte valid bits, item
// registers, scan pointers, zero-run counter and the result register.
// Depends on zrff_pkg; driven by zrff_ctrl through dp_cmd_t.
module zrff_dp
    import zrff_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    input  logic [OP_W-1:0]   op,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] data,
    input  logic [SIZE_W-1:0] size,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    output logic              ok,
    output logic [ADDR_W-1:0] result_addr
);

    // Only the first MEM_DEPTH bytes (at most 256) can ever be written; the rest always read zero.
    localparam int unsigned MEM_DEPTH = (POOL_DEPTH < 256) ? POOL_DEPTH : 256;
    localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
    localparam logic [SIZE_W-1:0] SIZE_CAP =
        (POOL_DEPTH < 511) ? SIZE_W'(POOL_DEPTH) : {SIZE_W{1'b1}};
    localparam logic [SIZE_W-1:0] MEM_TOP = SIZE_W'(MEM_DEPTH);

    logic [DATA_W-1:0]    mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] vld_reg;

    logic [SIZE_W-1:0] size_reg;
    logic [OP_W-1:0]   op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] data_reg;
    logic [SIZE_W-1:0] len_reg;
    logic [SIZE_W-1:0] rd_ptr_reg;
    logic [SIZE_W-1:0] chk_ptr_reg;
    logic              chk_vld_reg;
    logic [RUN_W-1:0]  run_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_hit_reg;
    logic              ok_reg;
    logic [ADDR_W-1:0] res_addr_reg;

    logic [SIZE_W-1:0] pool_n;
    logic [SIZE_W-1:0] last_ptr;
    logic              rd_in_pool;
    logic              rd_in_mem;
    logic              chk_in_mem;
    logic [MEM_AW-1:0] rd_idx;
    logic [MEM_AW-1:0] chk_idx;
    logic [MEM_AW-1:0] wr_idx;
    logic              chk_zero;
    logic [SIZE_W:0]   start_diff;
    logic              cand_big;
    logic [RUN_W-1:0]  run_need;
    logic [RUN_W-1:0]  run_inc;
    logic              fits;
    logic              addr_in_pool;

    always_comb
    begin
        if (size_reg == '0)
        begin
            pool_n = SIZE_W'(1);
        end
        else if (size_reg > SIZE_CAP)
        begin
            pool_n = SIZE_CAP;
        end
        else
        begin
            pool_n = size_reg;
        end
    end

    assign last_ptr     = pool_n - SIZE_W'(1);
    assign rd_in_pool   = rd_ptr_reg < pool_n;
    assign rd_in_mem    = rd_ptr_reg < MEM_TOP;
    assign chk_in_mem   = chk_ptr_reg < MEM_TOP;
    assign rd_idx       = rd_ptr_reg[MEM_AW-1:0];
    assign chk_idx      = chk_ptr_reg[MEM_AW-1:0];
    assign wr_idx       = addr_reg[MEM_AW-1:0];
    assign addr_in_pool = {1'b0, addr_reg} < pool_n;

    // An entry never written since the last clear reads as zero.
    assign chk_zero = !rd_hit_reg || (rd_data_reg == '0);

    // Candidate start for a run ending at the checked byte. The run counter
    // starts at one to stand for the free byte assumed before address zero.
    assign start_diff = {1'b0, chk_ptr_reg} - {1'b0, len_reg};
    assign cand_big   = !start_diff[SIZE_W] && start_diff[ADDR_W];
    assign run_need   = {1'b0, len_reg} + RUN_W'(1);
    assign run_inc    = (run_reg == '1) ? run_reg : run_reg + RUN_W'(1);
    assign fits       = chk_zero && (run_reg >= run_need) && !cand_big;

    always_comb
    begin
        sts.op           = op_reg;
        sts.len_zero     = (len_reg == '0);
        sts.addr_in_pool = addr_in_pool;
        sts.chk_vld      = chk_vld_reg;
        sts.chk_zero     = chk_zero;
        sts.chk_last     = (chk_ptr_reg == last_ptr);
        sts.fits         = fits;
        sts.cand_big     = cand_big;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(256);
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            vld_reg <= '0;
        end
        else if (cmd.write)
        begin
            vld_reg[wr_idx] <= 1'b1;
        end
        else if (cmd.clear && chk_in_mem)
        begin
            vld_reg[chk_idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[wr_idx] <= data_reg;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            addr_reg <= addr;
            data_reg <= data;
            len_reg  <= size;
        end
        if (cmd.start)
        begin
            rd_ptr_reg <= (op_reg == OP_FREE) ? {1'b0, addr_reg} : '0;
            run_reg    <= RUN_W'(1);
        end
        else
        begin
            if (cmd.issue)
            begin
                if (rd_in_pool)
                begin
                    rd_ptr_reg <= rd_ptr_reg + SIZE_W'(1);
                end
                chk_ptr_reg <= rd_ptr_reg;
                rd_hit_reg  <= rd_in_mem && vld_reg[rd_idx];
            end
            if (cmd.check)
            begin
                run_reg <= chk_zero ? run_inc : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_vld_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            chk_vld_reg <= 1'b0;
        end
        else if (cmd.issue)
        begin
            chk_vld_reg <= rd_in_pool;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.res)
            RES_FAIL:
            begin
                ok_reg       <= 1'b0;
                res_addr_reg <= '0;
            end
            RES_DONE:
            begin
                ok_reg       <= 1'b1;
                res_addr_reg <= '0;
            end
            RES_FOUND:
            begin
                ok_reg       <= 1'b1;
                res_addr_reg <= start_diff[ADDR_W-1:0];
            end
            default:
            begin
                ok_reg       <= ok_reg;
                res_addr_reg <= res_addr_reg;
            end
        endcase
    end

    assign ok          = ok_reg;
    assign result_addr = res_addr_reg;

    // A free only clears bytes that were checked and found in use.
    a_clear_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> (chk_vld_reg && !chk_zero))
        else $error("free cleared a byte that was not in use");

    a_write_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> addr_in_pool)
        else $error("byte write outside the pool");

    a_found_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res == RES_FOUND) |-> (fits && chk_vld_reg))
        else $error("allocation reported without a fitting run");

endmodule

@@ src/zrff_ctrl.sv @@
// Controller of the allocator: sequences decode, scans and the result beat.
// Depends on zrff_pkg; drives zrff_dp through dp_cmd_t, reads dp_sts_t.
module zrff_ctrl
    import zrff_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res    = RES_HOLD;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_RESP;
                case (sts.op)
                    OP_WRITE:
                    begin
                        if (sts.addr_in_pool)
                        begin
                            cmd.write = 1'b1;
                            cmd.res   = RES_DONE;
                        end
                        else
                        begin
                            cmd.res = RES_FAIL;
                        end
                    end
                    OP_ALLOC:
                    begin
                        if (sts.len_zero)
                        begin
                            cmd.res = RES_FAIL;
                        end
                        else
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_ALLOC;
                        end
                    end
                    OP_FREE:
                    begin
                        if (sts.addr_in_pool)
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_FREE;
                        end
                        else
                        begin
                            cmd.res = RES_FAIL;
                        end
                    end
                    default:
                    begin
                        cmd.res = RES_FAIL;
                    end
                endcase
            end
            ST_ALLOC:
            begin
                // Reads run one byte ahead of the check.
                cmd.issue = 1'b1;
                if (sts.chk_vld)
                begin
                    if (sts.fits)
                    begin
                        cmd.res    = RES_FOUND;
                        state_next = ST_RESP;
                    end
                    else if (sts.cand_big || sts.chk_last)
                    begin
                        cmd.res    = RES_FAIL;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        cmd.check = 1'b1;
                    end
                end
            end
            ST_FREE:
            begin
                cmd.issue = 1'b1;
                if (sts.chk_vld)
                begin
                    if (sts.chk_zero)
                    begin
                        cmd.res    = RES_DONE;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        cmd.clear = 1'b1;
                        if (sts.chk_last)
                        begin
                            cmd.res    = RES_DONE;
                            state_next = ST_RESP;
                        end
                    end
                end
            end
            ST_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted item not decoded next cycle");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res != RES_HOLD) |=> (state_reg == ST_RESP))
        else $error("result loaded without a result beat");

endmodule

@@ src/zero_run_first_fit_allocator_core.sv @@
// Top level of the zero-run first-fit allocator: controller plus datapath.
// Depends on zrff_pkg, zrff_ctrl and zrff_dp.
//
//  channel | signals                           | direction
//  --------+-----------------------------------+----------
//  in      | in_valid, in_ready, op, addr,     | in
//          | data, size                        |
//  out     | out_valid, out_ready, ok,         | out
//          | result_addr                       |
//  cfg     | cfg_wr_en, cfg_wr_data            | in
//
// A write, a failed check or an allocate of size zero goes from accept through
// the decode state to the result beat. A free clears bytes from addr until it meets a
// zero byte or the pool end, and an allocate scans up to the effective pool size,
// one pool byte per cycle through the single read port of the pool memory.
// Reset and every pool-size write clear the pool at once through per-byte
// valid bits. One item is in work at a time; a stalled result beat holds
// input acceptance off until it is taken.
module zero_run_first_fit_allocator_core
    import zrff_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   op,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] data,
    input  logic [SIZE_W-1:0] size,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic [ADDR_W-1:0] result_addr
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    zrff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    zrff_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op          (op),
        .addr        (addr),
        .data        (data),
        .size        (size),
        .cmd         (cmd),
        .sts         (sts),
        .ok          (ok),
        .result_addr (result_addr)
    );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for zero_run_first_fit_allocator_core: directed table, then random phases.
// Depends on zrff_pkg and the RTL of the block; the pool is mirrored here to predict each reply.
module testbench;
    import zrff_pkg::*;

    localparam int unsigned POOL_DEPTH = 256;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned ROW_COUNT = 24;
    localparam int unsigned PHASE_COUNT = 10;
    localparam int unsigned PHASE_ITEMS = 45;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] res_addr;
    } alloc_result_t;

    typedef struct packed {
        logic              cfg;
        logic [OP_W-1:0]   code;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        logic [SIZE_W-1:0] len;
        logic              typed;
        logic              ok;
        logic [ADDR_W-1:0] res_addr;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;
    logic              in_valid;
    logic              in_ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [SIZE_W-1:0] size;
    logic              out_valid;
    logic              out_ready;
    logic              ok;
    logic [ADDR_W-1:0] result_addr;

    // Mirror of the pool and its size register.
    logic [DATA_W-1:0] pool_image [POOL_DEPTH];
    logic [SIZE_W-1:0] pool_size_reg;

    alloc_result_t     pending_replies [$];
    int unsigned       mismatch_count = 0;
    bit                tx_calm = 1'b0;
    bit                rx_calm = 1'b0;

    // Rows with typed = 1 carry a reply that is plain from the block's rules; the rest use
    // the mirror.
    stim_row_t directed_rows [ROW_COUNT] = '{
        '{1'b0, OP_ALLOC,  8'd0,   8'h00, 9'd0,   1'b1, 1'b0, 8'd0},
        '{1'b0, OP_ALLOC,  8'd0,   8'h00, 9'd1,   1'b1, 1'b1, 8'd0},
        '{1'b0, OP_ALLOC,  8'd0,   8'h00, 9'd255, 1'b1, 1'b1, 8'd0},
        '{1'b0, OP_ALLOC,  8'd0,   8'h00, 9'd256, 1'b1, 1'b0, 8'd0},
        '{1'b0, OP_ALLOC,  8'd0,   8'h00, 9'd511, 1'b1, 1'b0, 8'd0},
        '{1'b0, OP_UNUSED, 8'd255, 8'hFF, 9'd511, 1'b1, 1'b0, 8'd0},
        '{1'b0, OP_WRITE,  8'd0,   8'hFF, 9'd0,   1'b1, 1'b1, 8'd0},
        '{1'b0, OP_WRITE,  8'd255, 8'h80, 9'd0,   1'b1, 1'b1, 8'd0},
        '{1'b0, OP_ALLOC,  8'd0,   8'h00, 9'd1,   1'b0, 1'b0, 8'd0},
        '{1'b0, OP_WRITE,  8'd5,   8'h01, 9'd0,   1'b1, 1'b1, 8'd0},
        '{1'b0, OP_ALLOC,  8'd0,   8'h00, 9'd3,   1'b0, 1'b0, 8'd0},
        '{1'b0, OP_WRITE,  8'd1,   8'h55, 9'd0,   1'b1, 1'b1, 8'd0},
        '{1'b0, OP_WRITE,  8'd2,   8'hAA, 9'd0,   1'b1, 1'b1, 8'd0},
        '{1'b0, OP_FREE,   8'd0,   8'h00, 9'd0,   1'b1, 1'b1, 8'd0},
        '{1'b0, OP_FREE,   8'd3,   8'h00, 9'd0,   1'b1, 1'b1, 8'd0},
        '{1'b0, OP_FREE,   8'd255, 8'h00, 9'd0,   1'b1, 1'b1, 8'd0},
        '{1'b0, OP_WRITE,  8'd128, 8'h7F, 9'd0,   1'b1, 1'b1, 8'd0},
        '{1'b0, OP_ALLOC,  8'd0,   8'h00, 9'd249, 1'b0, 1'b0, 8'd0},
        '{1'b1, OP_WRITE,  8'd0,   8'h00, 9'd1,   1'b0, 1'b0, 8'd0},
        '{1'b0, OP_WRITE,  8'd0,   8'h01, 9'd0,   1'b1, 1'b1, 8'd0},
        '{1'b0, OP_WRITE,  8'd1,   8'hFF, 9'd0,   1'b1, 1'b0, 8'd0},
        '{1'b0, OP_FREE,   8'd200, 8'h00, 9'd0,   1'b1, 1'b0, 8'd0},
        '{1'b0, OP_ALLOC,  8'd0,   8'h00, 9'd1,   1'b1, 1'b0, 8'd0},
        '{1'b0, OP_FREE,   8'd0,   8'h00, 9'd0,   1'b1, 1'b1, 8'd0}
    };

    // Sizes zero and above the depth saturate, so both ends of the range are covered.
    logic [SIZE_W-1:0] phase_sizes [PHASE_COUNT] = '{
        9'd16, 9'd0, 9'd40, 9'd256, 9'd7, 9'd511, 9'd100, 9'd300, 9'd1, 9'd24
    };

    zero_run_first_fit_allocator_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .addr        (addr),
        .data        (data),
        .size        (size),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .result_addr (result_addr)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int unsigned pool_limit();
        int unsigned n;
        n = pool_size_reg;
        if (n < 1) n = 1;
        if (n > POOL_DEPTH) n = POOL_DEPTH;
        return n;
    endfunction

    // Lowest start of a run of len zero bytes with a zero byte on each side inside the pool; start 0 needs none before.
    function automatic bit first_fit(input int unsigned len, input int unsigned n,
                                     output int unsigned start);
        bit fits;
        start = 0;
        if (len == 0) return 1'b0;
        for (int unsigned a = 0; a < 256 && a + len < n; a++)
        begin
            if (a > 0 && pool_image[a - 1] != '0) continue;
            fits = 1'b1;
            for (int unsigned k = 0; k <= len; k++)
            begin
                if (pool_image[a + k] != '0)
                begin
                    fits = 1'b0;
                    break;
                end
            end
            if (fits)
            begin
                start = a;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic alloc_result_t apply_pool_op(input logic [OP_W-1:0] code,
                                                    input logic [ADDR_W-1:0] a,
                                                    input logic [DATA_W-1:0] d,
                                                    input logic [SIZE_W-1:0] len);
        alloc_result_t r;
        int unsigned   n;
        int unsigned   p;
        int unsigned   found;
        n = pool_limit();
        r = '0;
        case (code)
            OP_WRITE:
            begin
                if (a < n)
                begin
                    pool_image[a] = d;
                    r.ok = 1'b1;
                end
            end
            OP_ALLOC:
            begin
                if (first_fit(len, n, found))
                begin
                    r.ok = 1'b1;
                    r.res_addr = found[ADDR_W-1:0];
                end
            end
            OP_FREE:
            begin
                if (a < n)
                begin
                    p = a;
                    while (p < n && pool_image[p] != '0)
                    begin
                        pool_image[p] = '0;
                        p++;
                    end
                    r.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic int unsigned draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic issue_item(input logic [OP_W-1:0] code, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d, input logic [SIZE_W-1:0] len,
                              input bit typed, input alloc_result_t typed_res,
                              output alloc_result_t predicted);
        int unsigned gap;
        gap = draw_wait(tx_calm);
        if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        addr     <= a;
        data     <= d;
        size     <= len;
        do @(posedge clk); while (!in_ready);
        predicted = apply_pool_op(code, a, d, len);
        pending_replies.push_back(typed ? typed_res : predicted);
    endtask

    // The pool size may only change with the block idle; the write also clears the pool.
    task automatic set_pool_size(input logic [SIZE_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pool_size_reg = value;
        foreach (pool_image[i]) pool_image[i] = '0;
        @(posedge clk);
    endtask

    initial
    begin
        alloc_result_t     got;
        logic [ADDR_W-1:0] claimed [$];
        logic [ADDR_W-1:0] base;
        logic [OP_W-1:0]   code;
        int unsigned       n;
        int unsigned       cap;
        int unsigned       len;
        int unsigned       pick;
        int unsigned       idx;
        int unsigned       done;

        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        op          <= OP_WRITE;
        addr        <= '0;
        data        <= '0;
        size        <= '0;
        pool_size_reg = 9'd256;
        foreach (pool_image[i]) pool_image[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cfg)
                set_pool_size(directed_rows[i].len);
            else
                issue_item(directed_rows[i].code, directed_rows[i].a, directed_rows[i].d,
                           directed_rows[i].len, directed_rows[i].typed,
                           {directed_rows[i].ok, directed_rows[i].res_addr}, got);
        end

        foreach (phase_sizes[ph])
        begin
            set_pool_size(phase_sizes[ph]);
            claimed.delete();
            done = 0;
            n = pool_limit();
            cap = (n < 12) ? n : 12;
            while (done < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    // Claim a block as a user would: allocate, then mark its bytes used while items remain.
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n)
                                                      : $urandom_range(1, cap);
                    issue_item(OP_ALLOC, '0, '0, len[SIZE_W-1:0], 1'b0, '0, got);
                    done++;
                    if (got.ok)
                    begin
                        base = got.res_addr;
                        for (int unsigned k = 0; k < len && done < PHASE_ITEMS; k++)
                        begin
                            issue_item(OP_WRITE, base + k[ADDR_W-1:0],
                                       DATA_W'($urandom_range(1, 255)), '0, 1'b0, '0, got);
                            done++;
                        end
                        claimed.push_back(base);
                    end
                end
                else if (pick < 65 && claimed.size() > 0)
                begin
                    idx = $urandom_range(0, claimed.size() - 1);
                    issue_item(OP_FREE, claimed[idx], '0, '0, 1'b0, '0, got);
                    claimed.delete(idx);
                    done++;
                end
                else
                begin
                    code = OP_W'($urandom_range(0, 3));
                    issue_item(code,
                               ADDR_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                   : $urandom_range(0, n - 1)),
                               DATA_W'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255)),
                               SIZE_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 511)
                                                                   : $urandom_range(1, cap)),
                               1'b0, '0, got);
                    if (code != OP_UNUSED) done++;
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Result side: ready may drop before each beat; in calm spells it stays high.
    initial
    begin
        int unsigned stall;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(rx_calm);
            if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result beat: ok=%0d addr=%0d", ok, result_addr);
                mismatch_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (want.ok !== ok || want.res_addr !== result_addr)
                begin
                    if (mismatch_count < 10)
                        $display("mismatch: expected ok=%0d addr=%0d, got ok=%0d addr=%0d",
                                 want.ok, want.res_addr, ok, result_addr);
                    mismatch_count++;
                end
            end
        end
    end

endmodule

@@ files.f @@
src/zrff_pkg.sv
src/zrff_dp.sv
src/zrff_ctrl.sv
src/zero_run_first_fit_allocator_core.sv
bench/testbench.sv
